### hdl/sorted_table_multichannel_pwm_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table PWM
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_MULTICHANNEL_PWM_ASSERT_SVH
`define SORTED_TABLE_MULTICHANNEL_PWM_ASSERT_SVH

// Same-cycle implication.
`define STMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define STMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/stmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table PWM package
// Shared widths, operation codes and the types passed between the lanes,
// the table merge and the top level.
// ----------------------------------------------------------------------------
package stmp_pkg;

	localparam int NCH    = 4;
	localparam int NENT   = NCH + 1;
	localparam int DUTY_W = 8;
	localparam int RANK_W = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int IDX_W  = $clog2(NENT);
	localparam int OP_W   = 2;
	localparam int IN_W   = NCH * DUTY_W;
	localparam int OUT_FIELDS_W = NCH + DUTY_W + 1;
	localparam int OUT_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [DUTY_W-1:0] FULL_ON = {DUTY_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_SET_DUTIES  = 2'd0,
		OP_PERIOD      = 2'd1,
		OP_COMPARE     = 2'd2
	} op_t;

	typedef logic [NCH-1:0][DUTY_W-1:0] duty_vec_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              on;
		logic              off_en;
	} lane_res_t;

	typedef struct packed {
		logic [NENT-1:0][NCH-1:0]    masks;
		logic [NENT-1:0][DUTY_W-1:0] times;
	} tbl_t;

endpackage

### hdl/stmp_rank_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank lane
// For one channel, counts the distinct duties below its own duty, which is
// the off table entry the channel belongs to.
// ----------------------------------------------------------------------------
module stmp_rank_lane (
	input  logic [stmp_pkg::DUTY_W-1:0] duty,
	input  stmp_pkg::duty_vec_t         duties,
	input  logic [stmp_pkg::NCH-1:0]    first,
	output stmp_pkg::lane_res_t         res
);
	import stmp_pkg::*;

	logic [RANK_W:0] cnt;

	always_comb begin
		cnt = '0;
		for (int d = 0; d < NCH; d++) begin
			if (first[d] && (duties[d] < duty)) begin
				cnt = cnt + (RANK_W + 1)'(1);
			end
		end
		res.rank   = cnt[RANK_W-1:0];
		res.on     = (duty != '0);
		res.off_en = (duty != FULL_ON);
	end

endmodule

### hdl/stmp_table_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table merge
// Combines the lane ranks into the on-mask and the off table entries.
// ----------------------------------------------------------------------------
module stmp_table_merge (
	input  stmp_pkg::duty_vec_t            duties,
	input  stmp_pkg::lane_res_t [stmp_pkg::NCH-1:0] lanes,
	output stmp_pkg::tbl_t                 tbl
);
	import stmp_pkg::*;

	always_comb begin
		tbl = '0;
		for (int c = 0; c < NCH; c++) begin
			tbl.masks[0][c] = lanes[c].on;
		end
		for (int k = 0; k < NCH; k++) begin
			for (int c = 0; c < NCH; c++) begin
				if (lanes[c].off_en && (lanes[c].rank == RANK_W'(k))) begin
					tbl.masks[k+1][c] = 1'b1;
					tbl.times[k] = tbl.times[k] | duties[c];
				end
			end
		end
	end

endmodule

### hdl/sorted_table_multichannel_pwm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table multichannel PWM
// Four-channel PWM driven by one compare value and double-buffered off tables.
// ----------------------------------------------------------------------------
// The slave stream carries one command item: tuser selects set duties, period
// start or compare match, and tdata carries the four channel duties.
// The master stream returns exactly one result item per command: the channel
// levels, the compare value to load next and a flag for a table swap.
// A set duties item ranks the duties in four parallel lanes and merges the
// ranks into the off table of the idle bank in the same cycle; a later
// compare match at a zero entry swaps the banks.
// The result appears on the master side in the cycle after acceptance, and
// the block takes one item per cycle while the receiver does not stall; the
// state update of the pin, compare and step registers sets that rate.
// The result sits in an output register, so a new item is accepted whenever
// that register is empty or is being emptied in the same cycle. If the
// receiver stalls, the result holds and s_tready stays low until it is taken.
// Reset turns all channels off, clears the compare value, the step index,
// both table banks and the pending swap.
// ----------------------------------------------------------------------------
module sorted_table_multichannel_pwm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [stmp_pkg::IN_W-1:0]    s_tdata,  // duty_a, duty_b, duty_c, duty_d
	input  logic [stmp_pkg::OP_W-1:0]    s_tuser,  // operation
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [stmp_pkg::OUT_W-1:0]   m_tdata   // pin_levels, compare_value, tables_swapped
);
	import stmp_pkg::*;

	duty_vec_t              duties;
	logic [NCH-1:0]         first;
	lane_res_t [NCH-1:0]    lanes;
	tbl_t                   built;
	tbl_t                   bank_q [2];
	tbl_t                   run;
	logic                   sel_q;
	logic                   sel_n;
	logic                   pend_q;
	logic                   pend_n;
	logic [IDX_W-1:0]       step_q;
	logic [IDX_W-1:0]       step_n;
	logic [IDX_W-1:0]       idx_inc;
	logic [NCH-1:0]         pin_q;
	logic [NCH-1:0]         pin_n;
	logic [DUTY_W-1:0]      cmp_q;
	logic [DUTY_W-1:0]      cmp_n;
	logic                   swap_n;
	logic                   swap_q;
	logic                   out_valid_q;
	logic                   accept;
	logic                   build_we;

	assign duties   = s_tdata;
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign run      = bank_q[sel_q];

	always_comb begin
		for (int d = 0; d < NCH; d++) begin
			first[d] = 1'b1;
			for (int e = 0; e < d; e++) begin
				if (duties[e] == duties[d]) begin
					first[d] = 1'b0;
				end
			end
		end
	end

	for (genvar g = 0; g < NCH; g++) begin : g_lane
		stmp_rank_lane u_lane (
			.duty   (duties[g]),
			.duties (duties),
			.first  (first),
			.res    (lanes[g])
		);
	end

	stmp_table_merge u_merge (
		.duties (duties),
		.lanes  (lanes),
		.tbl    (built)
	);

	assign idx_inc = (step_q < IDX_W'(NCH)) ? step_q + IDX_W'(1) : IDX_W'(NCH);

	always_comb begin
		sel_n    = sel_q;
		pend_n   = pend_q;
		step_n   = step_q;
		pin_n    = pin_q;
		cmp_n    = cmp_q;
		swap_n   = 1'b0;
		build_we = 1'b0;
		case (op_t'(s_tuser))
			OP_SET_DUTIES: begin
				build_we = 1'b1;
				pend_n   = 1'b1;
			end
			OP_PERIOD: begin
				step_n = '0;
				pin_n  = pin_q | run.masks[0];
				cmp_n  = run.times[0];
			end
			OP_COMPARE: begin
				step_n = idx_inc;
				pin_n  = pin_q & ~run.masks[idx_inc];
				if (run.times[idx_inc] != '0) begin
					cmp_n = run.times[idx_inc];
				end else if (pend_q) begin
					pend_n = 1'b0;
					sel_n  = ~sel_q;
					swap_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q[0]   <= '0;
			bank_q[1]   <= '0;
			sel_q       <= 1'b0;
			pend_q      <= 1'b0;
			step_q      <= '0;
			pin_q       <= '0;
			cmp_q       <= '0;
			swap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (build_we) begin
					bank_q[~sel_q] <= built;
				end
				sel_q  <= sel_n;
				pend_q <= pend_n;
				step_q <= step_n;
				pin_q  <= pin_n;
				cmp_q  <= cmp_n;
				swap_q <= swap_n;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({swap_q, cmp_q, pin_q});

	`include "sorted_table_multichannel_pwm_assert.svh"

	`STMP_ASSERT_NOW(a_step_range, 1'b1, step_q <= IDX_W'(NCH), "step index past table end")
	`STMP_ASSERT_NOW(a_swap_needs_pending, accept && swap_n,
		pend_q && (s_tuser == OP_COMPARE), "table swap without a pending build")
	`STMP_ASSERT_NEXT(a_accept_gives_result, accept, m_tvalid, "accepted item gave no result")

endmodule

### bench/pwm_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table PWM result checker
// Watches both streams of the sorted table PWM. It keeps its own copy of the
// channel order, both table banks, the step index and the pin and compare
// registers, and works out the levels, compare value and swap flag for each
// accepted command. Each returned result is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pwm_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [stmp_pkg::IN_W-1:0]    s_tdata,
	input  logic [stmp_pkg::OP_W-1:0]    s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [stmp_pkg::OUT_W-1:0]   m_tdata,
	output int                           errors,
	output int                           outstanding
);
	import stmp_pkg::*;

	typedef struct packed {
		logic              tables_swapped;
		logic [DUTY_W-1:0] compare_value;
		logic [NCH-1:0]    pin_levels;
	} pwm_result_t;

	logic [RANK_W-1:0] order_q [NCH];
	tbl_t              staged_tbl;
	tbl_t              live_tbl;
	logic              swap_armed;
	logic [IDX_W-1:0]  step_q;
	logic [NCH-1:0]    pins_q;
	logic [DUTY_W-1:0] compare_q;
	pwm_result_t       pwm_results_due [$];
	int                mismatches;

	function automatic void rebuild_staged(duty_vec_t duty);
		logic [RANK_W-1:0] held;
		logic [DUTY_W-1:0] level;
		int                k;
		int                j;

		for (int i = 1; i < NCH; i++) begin
			j = i;
			while (j > 0 && duty[order_q[j-1]] > duty[order_q[j]]) begin
				held         = order_q[j-1];
				order_q[j-1] = order_q[j];
				order_q[j]   = held;
				j--;
			end
		end
		staged_tbl = '0;
		k = 0;
		for (int i = 0; i < NCH; i++) begin
			level = duty[order_q[i]];
			if (level != 0)
				staged_tbl.masks[0][order_q[i]] = 1'b1;
			if (level != FULL_ON) begin
				staged_tbl.masks[k+1][order_q[i]] = 1'b1;
				staged_tbl.times[k]               = level;
			end
			if (i == NCH - 1 || level != duty[order_q[i+1]])
				k++;
		end
		swap_armed = 1'b1;
	endfunction

	function automatic pwm_result_t predict_pwm(logic [OP_W-1:0] op, duty_vec_t duty);
		pwm_result_t res;
		tbl_t        spare;

		res = '0;
		case (op)
			OP_SET_DUTIES: begin
				rebuild_staged(duty);
			end
			OP_PERIOD: begin
				step_q    = '0;
				pins_q    = pins_q | live_tbl.masks[0];
				compare_q = live_tbl.times[0];
			end
			OP_COMPARE: begin
				if (step_q < NCH)
					step_q = step_q + 1'b1;
				pins_q = pins_q & ~live_tbl.masks[step_q];
				if (live_tbl.times[step_q] != 0) begin
					compare_q = live_tbl.times[step_q];
				end else if (swap_armed) begin
					swap_armed         = 1'b0;
					spare              = staged_tbl;
					staged_tbl         = live_tbl;
					live_tbl           = spare;
					res.tables_swapped = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.pin_levels    = pins_q;
		res.compare_value = compare_q;
		return res;
	endfunction

	task automatic report_mismatch(string why, pwm_result_t want, pwm_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: pins exp %h got %h, cmp exp %h got %h, swap exp %b got %b",
				$time, why, want.pin_levels, got.pin_levels, want.compare_value,
				got.compare_value, want.tables_swapped, got.tables_swapped);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pwm_result_t got;
		pwm_result_t want;

		if (!arst_n) begin
			for (int i = 0; i < NCH; i++)
				order_q[i] = RANK_W'(i);
			staged_tbl = '0;
			live_tbl   = '0;
			swap_armed = 1'b0;
			step_q     = '0;
			pins_q     = '0;
			compare_q  = '0;
			pwm_results_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_FIELDS_W-1:0];
				if (pwm_results_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", '0, got);
				end else begin
					want = pwm_results_due.pop_front();
					if (got.pin_levels !== want.pin_levels ||
					    got.compare_value !== want.compare_value ||
					    got.tables_swapped !== want.tables_swapped)
						report_mismatch("result mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready)
				pwm_results_due.push_back(predict_pwm(s_tuser, duty_vec_t'(s_tdata)));
		end
		outstanding <= pwm_results_due.size();
		errors      <= mismatches;
	end

	initial begin
		mismatches = 0;
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table PWM testbench
// Drives command items into the sorted table PWM with random gaps and random
// receiver stalls: a directed opening over the duty extremes, ties, every
// operation and index saturation, then random periods with fresh duty sets,
// interrupted periods and random noise. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import stmp_pkg::*;

	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
	localparam int STIM_ITEMS = 900;
	localparam int QUIET_LIMIT = 500;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic [OP_W-1:0]   s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	int                errors;
	int                outstanding;
	int                items_sent;
	int                quiet_cycles;
	bit                gapless;

	sorted_table_multichannel_pwm u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pwm_result_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic duty_vec_t duties_of(int a, int b, int c, int d);
		duty_vec_t v;

		v[0] = DUTY_W'(a);
		v[1] = DUTY_W'(b);
		v[2] = DUTY_W'(c);
		v[3] = DUTY_W'(d);
		return v;
	endfunction

	function automatic duty_vec_t pick_duties();
		duty_vec_t v;

		for (int ch = 0; ch < NCH; ch++) begin
			case ($urandom_range(0, 7))
				0: v[ch] = '0;
				1: v[ch] = FULL_ON;
				2: v[ch] = (ch > 0) ? v[$urandom_range(0, ch - 1)] : DUTY_W'($urandom_range(1, 254));
				3: v[ch] = DUTY_W'($urandom_range(1, 3));
				4: v[ch] = DUTY_W'($urandom_range(252, 254));
				default: v[ch] = DUTY_W'($urandom());
			endcase
		end
		return v;
	endfunction

	task automatic send(logic [OP_W-1:0] op, duty_vec_t duty);
		int gap;

		gap = gapless ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= duty;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic run_period(int hits);
		send(OP_PERIOD, $urandom());
		repeat (hits) send(OP_COMPARE, $urandom());
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			int stall;

			stall = gapless ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tuser      <= OP_SET_DUTIES;
		quiet_cycles <= 0;
		items_sent   = 0;
		gapless      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_COMPARE, duties_of(255, 255, 255, 255));
		send(OP_PERIOD, duties_of(0, 0, 0, 0));
		send(OP_RESERVED, duties_of(170, 85, 255, 0));
		send(OP_SET_DUTIES, duties_of(40, 10, 30, 20));
		send(OP_COMPARE, duties_of(0, 0, 0, 0));
		run_period(6);
		send(OP_SET_DUTIES, duties_of(0, 0, 0, 0));
		send(OP_SET_DUTIES, duties_of(255, 255, 255, 255));
		run_period(2);
		send(OP_SET_DUTIES, duties_of(0, 255, 128, 128));
		run_period(5);
		send(OP_SET_DUTIES, duties_of(255, 0, 1, 254));
		send(OP_RESERVED, duties_of(1, 2, 3, 4));
		run_period(5);
		drain();

		while (items_sent < STIM_ITEMS) begin
			gapless = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					send(OP_SET_DUTIES, pick_duties());
					run_period($urandom_range(4, 6));
				end
				3, 4, 5: begin
					run_period($urandom_range(3, 6));
				end
				6: begin
					run_period($urandom_range(0, 3));
					send(OP_SET_DUTIES, pick_duties());
					run_period($urandom_range(0, 6));
				end
				7: begin
					drain();
				end
				default: begin
					repeat ($urandom_range(1, 4))
						send(OP_W'($urandom_range(0, 3)), $urandom());
				end
			endcase
		end
		gapless = 1'b0;
		drain();
		repeat (4) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
